FILE: hw/rtl/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
// No dependencies; imported by every module of the block but gwm_checker.
package gwm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int NPOS        = PATTERN_MAX + 1;
  localparam int LEN_W       = 6;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;

  localparam logic [7:0] STAR_CHAR     = 8'h2A;
  localparam logic [7:0] QUESTION_CHAR = 8'h3F;

  localparam logic [REG_IDX_W-1:0] REG_CHARS_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_THIRD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHARS_HIGH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH       = 3'd4;

  typedef logic [7:0]      char_t;
  typedef logic [NPOS-1:0] pos_set_t;

  typedef struct packed {
    logic  en;
    char_t pchar;
  } cell_cfg_t;

  typedef struct packed {
    logic load;
    logic restart;
  } step_t;

endpackage

FILE: hw/rtl/gwm_closure.sv
// Star closure of a position set: a set '*' bit sets its successor, through '*' runs.
// Built as one carry chain (add). Depends on gwm_pkg.
module gwm_closure
  import gwm_pkg::*;
(
  input  pos_set_t set_in,
  input  pos_set_t star_en,
  output pos_set_t set_out
);

  logic [NPOS:0] sum_w;
  pos_set_t      gen_w;
  pos_set_t      carry_w;

  // generate = star & set, propagate = star & ~set; carries are the filled bits
  assign gen_w   = star_en & set_in;
  assign sum_w   = {1'b0, star_en} + {1'b0, gen_w};
  assign carry_w = sum_w[NPOS-1:0] ^ star_en ^ gen_w;
  assign set_out = set_in | carry_w;

endmodule

FILE: hw/rtl/gwm_cell.sv
// One pattern position of the matcher: holds its active bit and hands
// a pass bit to the next position. Depends on gwm_pkg.
module gwm_cell
  import gwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  step_t     step,
  input  cell_cfg_t cfg,
  input  char_t     text_char,
  input  logic      home,
  input  logic      closed,
  input  logic      pass_in,
  output logic      active,
  output logic      pass_out,
  output logic      adv_bit
);

  logic active_r;
  logic active_nxt;
  logic live_w;
  logic star_w;
  logic stay_w;

  assign live_w   = cfg.en & closed;
  assign star_w   = (cfg.pchar == STAR_CHAR);
  assign stay_w   = live_w & star_w;
  assign pass_out = live_w & ~star_w &
                    ((cfg.pchar == QUESTION_CHAR) | (cfg.pchar == text_char));
  assign adv_bit  = stay_w | pass_in;

  always_comb begin
    active_nxt = active_r;
    if (step.load) begin
      active_nxt = step.restart ? home : adv_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= home;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign active = active_r;

endmodule

FILE: hw/rtl/glob_wildcard_matcher.sv
// Glob wildcard matcher top level: config registers, a row of position cells,
// result stage and output register. Depends on gwm_pkg, gwm_cell, gwm_closure.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one name byte per transfer with
//   in_end_of_text marking the last byte and in_empty_text signalling an empty
//   name (byte ignored). '?' in the pattern matches any byte, '*' any run.
//   Output channel (out_valid/out_ready) gives one out_matched per name.
//   Throughput: one byte per cycle while in_ready is high; the position
//   cells update their active bits on each transfer, so names stream back to back.
//   Result path: the result of a name is registered in the result stage,
//   then in the output register, after the transfer of its last byte.
//   Stall: a held result keeps out_valid and out_matched; the block still
//   takes one more ending byte into its result stage, then drops in_ready
//   until the output register drains.
//   Reset: pattern registers clear, the active set returns to position zero,
//   both stages empty. APB writes take effect at once; write only when idle.
module glob_wildcard_matcher
  import gwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_char,
  input  logic              in_end_of_text,
  input  logic              in_empty_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [3:0][DATA_W-1:0] pat_words_r;
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       eff_len;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  pos_set_t  active_set;
  pos_set_t  closed_set;
  pos_set_t  adv_set;
  pos_set_t  star_en;
  pos_set_t  home_set;
  pos_set_t  fin_closed;
  pos_set_t  fin_set_nxt;
  pos_set_t  fin_set_r;
  logic      fin_vld_r;
  logic      out_valid_r;
  logic      out_matched_r;
  logic      in_xfer;
  logic      done;
  logic      out_free;
  step_t     step;
  cell_cfg_t cell_cfg [NPOS];
  logic [NPOS-1:0] pass_w;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r <= '0;
      len_r       <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CHARS_LOW:    pat_words_r[0] <= pwdata;
        REG_CHARS_SECOND: pat_words_r[1] <= pwdata;
        REG_CHARS_THIRD:  pat_words_r[2] <= pwdata;
        REG_CHARS_HIGH:   pat_words_r[3] <= pwdata;
        REG_LENGTH:       len_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHARS_LOW:    prdata = pat_words_r[0];
      REG_CHARS_SECOND: prdata = pat_words_r[1];
      REG_CHARS_THIRD:  prdata = pat_words_r[2];
      REG_CHARS_HIGH:   prdata = pat_words_r[3];
      REG_LENGTH:       prdata = {{(DATA_W-LEN_W){1'b0}}, len_r};
      default:          prdata = '0;
    endcase
  end

  assign eff_len = (len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_r;

  // handshake
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = ~fin_vld_r | out_free;
  assign in_xfer  = in_valid & in_ready;
  assign done     = in_end_of_text | in_empty_text;

  assign step.load    = in_xfer;
  assign step.restart = done;

  // position row
  for (genvar i = 0; i < NPOS; i++) begin : g_pos
    if (i < PATTERN_MAX) begin : g_live
      assign cell_cfg[i].en    = (LEN_W'(i) < eff_len);
      assign cell_cfg[i].pchar = pat_words_r[i/8][(i%8)*8 +: 8];
    end else begin : g_tail
      assign cell_cfg[i] = '0;
    end
    assign star_en[i]  = cell_cfg[i].en & (cell_cfg[i].pchar == STAR_CHAR);
    assign home_set[i] = (i == 0);

    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .cfg       (cell_cfg[i]),
      .text_char (in_text_char),
      .home      (home_set[i]),
      .closed    (closed_set[i]),
      .pass_in   ((i == 0) ? 1'b0 : pass_w[(i == 0) ? 0 : i-1]),
      .active    (active_set[i]),
      .pass_out  (pass_w[i]),
      .adv_bit   (adv_set[i])
    );
  end

  gwm_closure u_close_row (
    .set_in  (active_set),
    .star_en (star_en),
    .set_out (closed_set)
  );

  // result stage
  assign fin_set_nxt = in_empty_text ? active_set : adv_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (in_xfer & done) begin
      fin_vld_r <= 1'b1;
    end else if (out_free) begin
      fin_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer & done) begin
      fin_set_r <= fin_set_nxt;
    end
  end

  gwm_closure u_close_fin (
    .set_in  (fin_set_r),
    .star_en (star_en),
    .set_out (fin_closed)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_matched_r <= fin_closed[eff_len];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

FILE: hw/rtl/gwm_checker.sv
// Port-level checks for glob_wildcard_matcher, attached by bind.
// Depends on the top level's ports only.
module gwm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_end_of_text,
  input logic in_empty_text,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched))
    else $error("result changed while stalled");

  // a new result follows an ending transfer through the result stage and output register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_end_of_text || in_empty_text), 2))
    else $error("result without an ending transfer");

  // input only stalls behind a held result
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_end_of_text (in_end_of_text),
  .in_empty_text  (in_empty_text),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_matched    (out_matched)
);

FILE: dv/glob_wildcard_matcher_tb.sv
// Testbench for glob_wildcard_matcher: directed and random names against
// configured wildcard patterns, checked by an in-bench position-set predictor.
// Depends on gwm_pkg and the glob_wildcard_matcher RTL.
module glob_wildcard_matcher_tb;
  import gwm_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_COUNT  = 16;
  localparam int PHASE_ITEMS  = 85;

  typedef struct packed {
    char_t text_char;
    logic  end_of_text;
    logic  empty_text;
  } name_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_text_char = '0;
  logic              in_end_of_text = 1'b0;
  logic              in_empty_text = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_matched;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of the block
  char_t             pat_chars [PATTERN_MAX];
  logic [LEN_W-1:0]  pat_len = '0;
  pos_set_t          live_positions = pos_set_t'(1);

  name_byte_t        pending_q [$];
  logic              expected_matches [$];
  name_byte_t        on_bus;
  int                queued_count = 0;
  int                accepted_count = 0;
  int                result_count = 0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              want;
  bit                have_exp;

  glob_wildcard_matcher u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_char   (in_text_char),
    .in_end_of_text (in_end_of_text),
    .in_empty_text  (in_empty_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_matched    (out_matched),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  function automatic int pattern_span();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
  endfunction

  // a live position sitting on a star also makes the next position live
  function automatic pos_set_t close_stars(pos_set_t s);
    int n;
    n = pattern_span();
    for (int i = 0; i < n; i++) begin
      if (s[i] && pat_chars[i] == STAR_CHAR) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  function automatic pos_set_t consume_char(pos_set_t s, char_t c);
    pos_set_t nxt;
    int       n;
    nxt = '0;
    n   = pattern_span();
    s   = close_stars(s);
    for (int i = 0; i < n; i++) begin
      if (s[i]) begin
        if (pat_chars[i] == STAR_CHAR) nxt[i] = 1'b1;
        else if (pat_chars[i] == QUESTION_CHAR || pat_chars[i] == c) nxt[i+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  task automatic track_name_byte(input name_byte_t b);
    pos_set_t fin;
    if (!b.empty_text) live_positions = consume_char(live_positions, b.text_char);
    if (b.empty_text || b.end_of_text) begin
      fin = close_stars(live_positions);
      expected_matches.insert(expected_matches.size(), fin[pattern_span()]);
      live_positions = pos_set_t'(1);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_count++;
        track_name_byte(on_bus);
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_q.pop_front();
          in_valid       <= 1'b1;
          in_text_char   <= on_bus.text_char;
          in_end_of_text <= on_bus.end_of_text;
          in_empty_text  <= on_bus.empty_text;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        have_exp = expected_matches.size() != 0;
        want     = have_exp ? expected_matches.pop_front() : 1'bx;
        if (!have_exp || out_matched !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected %b, got %b", result_count, want, out_matched);
        end
        result_count++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("glob_wildcard_matcher: mismatch");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_count != queued_count || expected_matches.size() != 0);
    // every result has been received; pad with idle clock edges before going on
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LENGTH) begin
      pat_len = val[LEN_W-1:0];
    end else begin
      for (int k = 0; k < 8; k++) pat_chars[int'(idx) * 8 + k] = val[8*k +: 8];
    end
  endtask

  task automatic write_pattern(input char_t chars [PATTERN_MAX], input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] word;
    wait_idle();
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 8; k++) word[8*k +: 8] = chars[w*8 + k];
      write_reg(REG_IDX_W'(w), word);
    end
    write_reg(REG_LENGTH, DATA_W'(len));
  endtask

  task automatic write_text_pattern(input string s, input logic [LEN_W-1:0] len);
    char_t chars [PATTERN_MAX];
    for (int k = 0; k < PATTERN_MAX; k++)
      chars[k] = (k < s.len()) ? char_t'(s[k]) : char_t'($urandom_range(0, 255));
    write_pattern(chars, len);
  endtask

  task automatic push_item(input char_t c, input logic last, input logic empty);
    name_byte_t b;
    b.text_char   = c;
    b.end_of_text = last;
    b.empty_text  = empty;
    pending_q.insert(pending_q.size(), b);
    queued_count++;
  endtask

  task automatic push_text(input string s);
    if (s.len() == 0) push_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    for (int i = 0; i < s.len(); i++) push_item(char_t'(s[i]), i == s.len() - 1, 1'b0);
  endtask

  function automatic char_t pick_char();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return char_t'($urandom_range(0, 255));
    if (r == 1) return STAR_CHAR;
    if (r == 2) return QUESTION_CHAR;
    return char_t'(8'h61 + $urandom_range(0, 2));
  endfunction

  function automatic char_t pick_pattern_char();
    int r;
    r = $urandom_range(0, 15);
    if (r <= 1) return char_t'($urandom_range(0, 255));
    if (r <= 4) return STAR_CHAR;
    if (r <= 6) return QUESTION_CHAR;
    return char_t'(8'h61 + $urandom_range(0, 2));
  endfunction

  // mostly names built to fit the pattern, some corrupted, some pure noise
  task automatic queue_random_name();
    char_t txt [$];
    int    kind;
    int    n;
    kind = $urandom_range(0, 9);
    n    = pattern_span();
    if (kind <= 5) begin
      for (int i = 0; i < n; i++) begin
        if (pat_chars[i] == STAR_CHAR)
          repeat ($urandom_range(0, 2)) txt.insert(txt.size(), pick_char());
        else if (pat_chars[i] == QUESTION_CHAR) txt.insert(txt.size(), pick_char());
        else txt.insert(txt.size(), pat_chars[i]);
      end
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 2))
          0: begin
            if (txt.size() != 0) txt[$urandom_range(0, txt.size() - 1)] = pick_char();
          end
          1: begin
            if (txt.size() != 0) txt.delete($urandom_range(0, txt.size() - 1));
          end
          default: begin
            txt.insert($urandom_range(0, txt.size()), pick_char());
          end
        endcase
      end
    end else if (kind <= 7) begin
      repeat ($urandom_range(0, 8)) begin
        if (n != 0 && $urandom_range(0, 1))
          txt.insert(txt.size(), pat_chars[$urandom_range(0, n - 1)]);
        else txt.insert(txt.size(), pick_char());
      end
    end else begin
      repeat ($urandom_range(0, 6)) txt.insert(txt.size(), char_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      // name cut short by the empty flag
      foreach (txt[i]) push_item(txt[i], 1'b0, 1'b0);
      push_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else if (txt.size() == 0) begin
      push_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (txt[i]) push_item(txt[i], i == txt.size() - 1, 1'b0);
    end
  endtask

  initial begin
    char_t            chars [PATTERN_MAX];
    logic [LEN_W-1:0] len;
    int               target;
    for (int k = 0; k < PATTERN_MAX; k++) pat_chars[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern: only the empty name matches
    push_text("");
    push_text("q");

    write_text_pattern("a*?b*", 6'd5);
    push_text("axb");
    push_text("ab");
    push_text("a*?b");
    push_item("a", 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);

    // length above the maximum is clamped
    write_text_pattern("********************************", 6'd63);
    push_text("");
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);

    for (int k = 0; k < PATTERN_MAX; k++) chars[k] = (k < PATTERN_MAX - 1) ? STAR_CHAR : 8'hFF;
    write_pattern(chars, 6'd40);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      for (int k = 0; k < PATTERN_MAX; k++) chars[k] = pick_pattern_char();
      case (p)
        0: len = 6'd63;
        1: len = 6'd32;
        2: begin
          len = 6'd0;
          for (int k = 0; k < PATTERN_MAX; k++) chars[k] = (k < 8) ? 8'hFF : 8'h00;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 6'd0;
            1: len = LEN_W'($urandom_range(32, 63));
            2: len = LEN_W'($urandom_range(13, 32));
            default: len = LEN_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      write_pattern(chars, len);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      target = queued_count + PHASE_ITEMS;
      while (queued_count < target) queue_random_name();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("glob_wildcard_matcher: match");
    end else begin
      $display("glob_wildcard_matcher: mismatch");
    end
    $finish;
  end

endmodule

FILE: glob_wildcard_matcher.f
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_closure.sv
hw/rtl/gwm_cell.sv
hw/rtl/glob_wildcard_matcher.sv
hw/rtl/gwm_checker.sv
dv/glob_wildcard_matcher_tb.sv
